@@ src/swlct_pkg.sv @@
`default_nettype none

package swlct_pkg;

    // command codes carried in s_tuser
    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_START_STOP = 3'd1,
        CMD_LAP_RESET  = 3'd2,
        CMD_CD_SET     = 3'd3,
        CMD_CD_PAUSE   = 3'd4,
        CMD_CD_CLEAR   = 3'd5,
        CMD_READ_LAP   = 3'd6
    } cmd_t;

    // countdown modes as reported on the output
    typedef enum logic [1:0] {
        CD_IDLE   = 2'd0,
        CD_RUN    = 2'd1,
        CD_PAUSED = 2'd2
    } cd_mode_t;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_RDLAP = 1'b1
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic exec;     // input transfer, run the command
        logic rd_load;  // lap memory data ready, build the read result
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;  // command on the input is a lap read
    } dp_stat_t;

    // stream widths
    localparam int IN_DATA_W = 40;
    localparam int IN_USER_W = 8;
    localparam int OUT_W     = 144;

    // input field positions
    localparam int IN_LOAD_LSB = 0;
    localparam int IN_IDX_LSB  = 32;

    // output field positions
    localparam int OUT_SW_LSB    = 0;
    localparam int OUT_RUN_BIT   = 32;
    localparam int OUT_CD_LSB    = 33;
    localparam int OUT_MODE_LSB  = 65;
    localparam int OUT_EXP_BIT   = 67;
    localparam int OUT_CNT_LSB   = 68;
    localparam int OUT_TOT_LSB   = 73;
    localparam int OUT_SPL_LSB   = 105;
    localparam int OUT_VALID_BIT = 137;
    localparam int OUT_DROP_BIT  = 138;
    localparam int OUT_USED_W    = 139;

endpackage

`default_nettype wire

@@ src/swlct_ctrl.sv @@
`default_nettype none

module swlct_ctrl
    import swlct_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      ctl
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_load;

    // input transfer when idle and the output slot frees up
    assign accept   = s_tvalid && s_tready;
    assign out_load = (accept && !stat.is_read) || (state_reg == ST_RDLAP);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && stat.is_read)
                    state_next = ST_RDLAP;
            end
            ST_RDLAP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
        ctl.exec    = s_tvalid && (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
        ctl.rd_load = (state_reg == ST_RDLAP);
    end

    // output slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ src/swlct_dp.sv @@
`default_nettype none

module swlct_dp
    import swlct_pkg::*;
#(
    parameter int LAP_DEPTH = 16,
    parameter int TIME_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    input  wire logic [IN_USER_W-1:0] s_tuser,
    input  wire ctl_cmd_t             ctl,
    output dp_stat_t                  stat,
    output logic [OUT_W-1:0]          m_tdata
);

    localparam int TW  = TIME_BITS;
    localparam int AW  = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
    localparam int CW  = $clog2(LAP_DEPTH + 1);
    localparam int IXW = (CW > 4) ? CW : 4;

    cmd_t             cmd;
    logic [TW-1:0]    load_val;
    logic [3:0]       lap_index;
    logic [AW-1:0]    rd_addr;

    logic [TW-1:0]    sw_elapsed_reg, sw_elapsed_next;
    logic             sw_run_reg, sw_run_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [TW-1:0]    last_total_reg, last_total_next;
    logic [TW-1:0]    cd_rem_reg, cd_rem_next;
    cd_mode_t         cd_mode_reg, cd_mode_next;
    logic             cd_armed_reg, cd_armed_next;
    logic             rd_hit_reg, rd_hit_next;

    logic             lap_wr;
    logic [TW-1:0]    lap_tot, lap_spl;
    logic             expired, lvalid, ldrop;

    logic [2*TW-1:0]  lap_mem [LAP_DEPTH];
    logic [2*TW-1:0]  rd_data_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] exec_word, read_word;

    // input field unpacking
    assign cmd       = cmd_t'(s_tuser[2:0]);
    assign load_val  = TW'(s_tdata[IN_LOAD_LSB +: 32]);
    assign lap_index = s_tdata[IN_IDX_LSB +: 4];
    assign rd_addr   = AW'(lap_index);
    assign stat.is_read = (cmd == CMD_READ_LAP);

    // result word packing, lowest field first
    function automatic logic [OUT_W-1:0] pack_word(
        input logic [TW-1:0] sw,
        input logic          run,
        input logic [TW-1:0] cd,
        input cd_mode_t      mode,
        input logic          exp,
        input logic [CW-1:0] cnt,
        input logic [TW-1:0] tot,
        input logic [TW-1:0] spl,
        input logic          vld,
        input logic          drp
    );
        logic [OUT_W-1:0] w;
        w = '0;
        w[OUT_SW_LSB +: 32]   = 32'(sw);
        w[OUT_RUN_BIT]        = run;
        w[OUT_CD_LSB +: 32]   = 32'(cd);
        w[OUT_MODE_LSB +: 2]  = mode;
        w[OUT_EXP_BIT]        = exp;
        w[OUT_CNT_LSB +: 5]   = 5'(cnt);
        w[OUT_TOT_LSB +: 32]  = 32'(tot);
        w[OUT_SPL_LSB +: 32]  = 32'(spl);
        w[OUT_VALID_BIT]      = vld;
        w[OUT_DROP_BIT]       = drp;
        return w;
    endfunction

    // command execution
    always_comb
    begin
        sw_elapsed_next = sw_elapsed_reg;
        sw_run_next     = sw_run_reg;
        count_next      = count_reg;
        last_total_next = last_total_reg;
        cd_rem_next     = cd_rem_reg;
        cd_mode_next    = cd_mode_reg;
        cd_armed_next   = cd_armed_reg;
        rd_hit_next     = rd_hit_reg;
        lap_wr          = 1'b0;
        lap_tot         = '0;
        lap_spl         = '0;
        expired         = 1'b0;
        lvalid          = 1'b0;
        ldrop           = 1'b0;
        if (ctl.exec)
        begin
            case (cmd)
                CMD_TICK:
                begin
                    // stopwatch saturates at full scale
                    if (sw_run_reg && (sw_elapsed_reg != '1))
                        sw_elapsed_next = sw_elapsed_reg + TW'(1);
                    if (cd_mode_reg == CD_RUN)
                    begin
                        if (cd_rem_reg <= TW'(1))
                        begin
                            cd_rem_next   = '0;
                            cd_mode_next  = CD_IDLE;
                            cd_armed_next = 1'b0;
                            expired       = 1'b1;
                        end
                        else
                        begin
                            cd_rem_next = cd_rem_reg - TW'(1);
                        end
                    end
                end
                CMD_START_STOP:
                begin
                    sw_run_next = !sw_run_reg;
                end
                CMD_LAP_RESET:
                begin
                    if (sw_run_reg)
                    begin
                        if (count_reg < CW'(LAP_DEPTH))
                        begin
                            // split against the previous lap total
                            lap_tot         = sw_elapsed_reg;
                            lap_spl         = (count_reg == '0) ? sw_elapsed_reg
                                                : sw_elapsed_reg - last_total_reg;
                            lap_wr          = 1'b1;
                            last_total_next = sw_elapsed_reg;
                            count_next      = count_reg + CW'(1);
                            lvalid          = 1'b1;
                        end
                        else
                        begin
                            ldrop = 1'b1;
                        end
                    end
                    else
                    begin
                        sw_elapsed_next = '0;
                        count_next      = '0;
                    end
                end
                CMD_CD_SET:
                begin
                    cd_rem_next   = load_val;
                    cd_mode_next  = CD_RUN;
                    cd_armed_next = (load_val != '0);
                end
                CMD_CD_PAUSE:
                begin
                    if (cd_armed_reg)
                    begin
                        if (cd_mode_reg == CD_RUN)
                            cd_mode_next = CD_PAUSED;
                        else if (cd_mode_reg == CD_PAUSED)
                            cd_mode_next = CD_RUN;
                    end
                end
                CMD_CD_CLEAR:
                begin
                    cd_rem_next   = '0;
                    cd_mode_next  = CD_IDLE;
                    cd_armed_next = 1'b0;
                end
                CMD_READ_LAP:
                begin
                    rd_hit_next = (IXW'(lap_index) < IXW'(count_reg));
                end
                default:
                begin
                end
            endcase
        end
    end

    // result words for a plain command and for a lap read
    assign exec_word = pack_word(sw_elapsed_next, sw_run_next, cd_rem_next, cd_mode_next,
                                 expired, count_next, lap_tot, lap_spl, lvalid, ldrop);
    assign read_word = pack_word(sw_elapsed_reg, sw_run_reg, cd_rem_reg, cd_mode_reg,
                                 1'b0, count_reg,
                                 rd_hit_reg ? rd_data_reg[TW-1:0] : '0,
                                 rd_hit_reg ? rd_data_reg[2*TW-1:TW] : '0,
                                 rd_hit_reg, 1'b0);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_elapsed_reg <= '0;
            sw_run_reg     <= 1'b0;
            count_reg      <= '0;
            last_total_reg <= '0;
            cd_rem_reg     <= '0;
            cd_mode_reg    <= CD_IDLE;
            cd_armed_reg   <= 1'b0;
            rd_hit_reg     <= 1'b0;
        end
        else
        begin
            sw_elapsed_reg <= sw_elapsed_next;
            sw_run_reg     <= sw_run_next;
            count_reg      <= count_next;
            last_total_reg <= last_total_next;
            cd_rem_reg     <= cd_rem_next;
            cd_mode_reg    <= cd_mode_next;
            cd_armed_reg   <= cd_armed_next;
            rd_hit_reg     <= rd_hit_next;
        end
    end

    // lap memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (lap_wr)
            lap_mem[count_reg[AW-1:0]] <= {lap_spl, lap_tot};
        if (ctl.exec && stat.is_read)
            rd_data_reg <= lap_mem[rd_addr];
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (ctl.exec && !stat.is_read)
            out_data_reg <= exec_word;
        else if (ctl.rd_load)
            out_data_reg <= read_word;
    end

    assign m_tdata = out_data_reg;

endmodule

`default_nettype wire

@@ src/stopwatch_lap_countdown_timer_top.sv @@
// stopwatch with lap memory and countdown timer, one command per input transfer
// results go through the output register; read_lap first through the lap memory read register
// throughput: 1 command per cycle unless the output stalls; read_lap holds input in ST_RDLAP
// ST_RDLAP waits on the registered read of the lap memory
// a result waits in an output register; the next command is taken as it drains
// reset: rst_n asynchronous, active low; clears times, modes and lap count, not the lap memory
`default_nettype none

module stopwatch_lap_countdown_timer_top
    import swlct_pkg::*;
#(
    parameter int LAP_DEPTH = 16,
    parameter int TIME_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // countdown_load_ms[31:0], lap_index[35:32], zero pad
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    // command[2:0], zero pad
    input  wire logic [IN_USER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // stopwatch_ms[31:0], stopwatch_running[32], countdown_ms[64:33],
    // countdown_state[66:65], countdown_expired[67], lap_count[72:68],
    // lap_total_ms[104:73], lap_split_ms[136:105], lap_valid[137],
    // lap_dropped[138], zero pad
    output logic [OUT_W-1:0]          m_tdata
);

    ctl_cmd_t ctl;
    dp_stat_t stat;

    // sequencing and output handshake
    swlct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // timers, lap memory and result register
    swlct_dp #(
        .LAP_DEPTH (LAP_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .ctl     (ctl),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire

@@ src/swlct_checker.sv @@
`default_nettype none

module swlct_checker
    import swlct_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a lap is either delivered or dropped, never both
    a_lap_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[OUT_VALID_BIT] && m_tdata[OUT_DROP_BIT]))
        else $error("lap valid and dropped together");

    // lap fields are zero without a lap
    a_lap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[OUT_VALID_BIT] |-> (m_tdata[OUT_SPL_LSB+31:OUT_TOT_LSB] == '0))
        else $error("lap fields set without a lap");

    // expiry leaves the countdown idle at zero
    a_expire: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OUT_EXP_BIT] |->
            (m_tdata[OUT_MODE_LSB +: 2] == CD_IDLE) && (m_tdata[OUT_CD_LSB +: 32] == '0))
        else $error("expiry with countdown still loaded");

    // countdown mode never takes the unused code
    a_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_MODE_LSB +: 2] != 2'd3))
        else $error("countdown state out of range");

endmodule

bind stopwatch_lap_countdown_timer_top swlct_checker u_swlct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
